>>> rtl/sgpa_pkg.sv
// Package for the staggered-grid particle advection block.
// Item, configuration and kind types, grid geometry constants, fixed-point helpers.
// No dependencies.
package sgpa_pkg;

	localparam int GRID_BITS  = 6;
	localparam int IDX_BITS   = 10;
	localparam int BANK_AW    = 2 * (GRID_BITS - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int GRID_MAX   = (1 << GRID_BITS) - 1;

	// divider: 6 integer and 16 fraction quotient bits
	localparam int FW = 16;
	localparam int QW = GRID_BITS + FW;

	localparam logic [FW:0] ONE_Q = 17'h10000;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam int APB_AW = 5;

	localparam logic [1:0] FUNC_WR_U   = 2'd0;
	localparam logic [1:0] FUNC_WR_V   = 2'd1;
	localparam logic [1:0] FUNC_ADVECT = 2'd2;

	localparam logic [2:0] REG_TIME_STEP   = 3'd0;
	localparam logic [2:0] REG_CELL_WIDTH  = 3'd1;
	localparam logic [2:0] REG_CELL_HEIGHT = 3'd2;
	localparam logic [2:0] REG_SEED_X      = 3'd3;
	localparam logic [2:0] REG_SEED_Y      = 3'd4;
	localparam logic [2:0] REG_SEED_STEP_X = 3'd5;
	localparam logic [2:0] REG_SEED_STEP_Y = 3'd6;

	typedef enum logic [1:0] {
		KIND_WR_U   = 2'd0,
		KIND_WR_V   = 2'd1,
		KIND_ADVECT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [GRID_BITS-1:0]  column;
		logic [GRID_BITS-1:0]  grid_row;
		logic signed [31:0]    velocity;
		logic signed [31:0]    pos_x;
		logic signed [31:0]    pos_y;
		logic [IDX_BITS-1:0]   particle_index;
	} item_t;

	// dx/dy already have zero replaced by one LSB
	typedef struct packed {
		logic [30:0]        time_step;
		logic [30:0]        dx;
		logic [30:0]        dy;
		logic signed [31:0] seed_x;
		logic signed [31:0] seed_y;
		logic signed [31:0] seed_step_x;
		logic signed [31:0] seed_step_y;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// round half up to Q16.16
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t >>> 16;
	endfunction

	// a*(1-f) + b*f, unscaled by 2^16
	function automatic logic signed [51:0] lerp(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [FW:0] f);
		logic signed [32:0] diff;
		logic signed [51:0] r;
		diff = 33'(b) - 33'(a);
		r = (52'(a) <<< 16) + 52'(diff * $signed({1'b0, f}));
		return r;
	endfunction

endpackage

>>> rtl/sgpa_in_if.sv
// Input item channel of the particle advection block.
// Depends on sgpa_pkg for field widths.
interface sgpa_in_if;
	import sgpa_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 func;
	logic [GRID_BITS-1:0]       column;
	logic [GRID_BITS-1:0]       grid_row;
	logic signed [31:0]         velocity;
	logic signed [31:0]         pos_x;
	logic signed [31:0]         pos_y;
	logic [IDX_BITS-1:0]        particle_index;

	modport source(output valid, func, column, grid_row, velocity, pos_x, pos_y,
		particle_index, input ready);
	modport sink(input valid, func, column, grid_row, velocity, pos_x, pos_y,
		particle_index, output ready);
endinterface

>>> rtl/sgpa_out_if.sv
// Result channel of the particle advection block.
// No dependencies.
interface sgpa_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic               respawned;

	modport source(output valid, new_x, new_y, respawned, input ready);
	modport sink(input valid, new_x, new_y, respawned, output ready);
endinterface

>>> rtl/sgpa_front.sv
// Front end: accepts input beats, classifies func, drops unused codes.
// Depends on sgpa_pkg and sgpa_in_if.
module sgpa_front (
	input  logic            clk,
	input  logic            arst_n,
	sgpa_in_if.sink         in_ch,
	input  logic            full,
	output logic            push,
	output sgpa_pkg::item_t item
);
	import sgpa_pkg::*;

	logic  vld_q;
	item_t item_q;
	logic  keep;
	kind_t kind;
	logic  acc;

	always_comb begin
		keep = 1'b1;
		kind = KIND_ADVECT;
		unique case (in_ch.func)
			FUNC_WR_U:   kind = KIND_WR_U;
			FUNC_WR_V:   kind = KIND_WR_V;
			FUNC_ADVECT: kind = KIND_ADVECT;
			default:     keep = 1'b0;
		endcase
	end

	assign push        = vld_q && !full;
	assign in_ch.ready = !vld_q || !full;
	assign acc         = in_ch.valid && in_ch.ready;
	assign item        = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			if (push)
				vld_q <= 1'b0;
			if (acc && keep)
				vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_q.kind           <= kind;
			item_q.column         <= in_ch.column;
			item_q.grid_row       <= in_ch.grid_row;
			item_q.velocity       <= in_ch.velocity;
			item_q.pos_x          <= in_ch.pos_x;
			item_q.pos_y          <= in_ch.pos_y;
			item_q.particle_index <= in_ch.particle_index;
		end
	end
endmodule

>>> rtl/sgpa_fifo.sv
// Short item queue between front and back ends.
// Depends on sgpa_pkg.
module sgpa_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sgpa_pkg::item_t din,
	output logic            full,
	input  logic            pop,
	output sgpa_pkg::item_t dout,
	output logic            empty
);
	import sgpa_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end
endmodule

>>> rtl/sgpa_div.sv
// Pipelined restoring divider: cell index and Q1.16 fraction along one axis.
// One quotient bit per stage; depends on sgpa_pkg.
module sgpa_div #(
	parameter int HI   = 63,
	parameter bit HALF = 1'b0
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [31:0]       p,
	input  logic [30:0]              d,
	output logic [sgpa_pkg::GRID_BITS-1:0] k,
	output logic [sgpa_pkg::FW:0]    f
);
	import sgpa_pkg::*;

	localparam int RW = 40;

	logic [32:0]        den;
	logic signed [34:0] n;
	logic [38:0]        lim;
	logic               neg, ovf;

	logic [RW-1:0] rem_q [QW+1];
	logic [QW-1:0] quo_q [QW+1];
	logic [QW:0]   neg_q, ovf_q;

	always_comb begin
		den = HALF ? {1'b0, d, 1'b0} : {2'b0, d};
		n   = HALF ? (35'(p) <<< 1) + $signed({4'b0, d}) : 35'(p);
		lim = 39'(den) * 39'(HI);
		neg = n[34];
		ovf = !neg && ({5'b0, n[33:0]} >= lim);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= (neg || ovf) ? '0 : RW'(n[33:0]);
			quo_q[0] <= '0;
			neg_q    <= {neg_q[QW-1:0], neg};
			ovf_q    <= {ovf_q[QW-1:0], ovf};
		end
	end

	for (genvar s = 1; s <= QW; s++) begin : g_stage
		localparam int B = QW - s;
		logic [RW-1:0] rr, trial;
		logic          ge;

		always_comb begin
			if (B >= FW) begin
				rr    = rem_q[s-1];
				trial = RW'(den) << (B - FW);
			end else begin
				rr    = rem_q[s-1] << 1;
				trial = RW'(den);
			end
			ge = (rr >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s] <= ge ? rr - trial : rr;
				quo_q[s] <= quo_q[s-1] | (ge ? (QW'(1) << B) : '0);
			end
		end
	end

	assign k = ovf_q[QW] ? GRID_BITS'(HI) : quo_q[QW][QW-1:FW] + 1'b1;
	assign f = neg_q[QW] ? '0 : (ovf_q[QW] ? ONE_Q : {1'b0, quo_q[QW][FW-1:0]});
endmodule

>>> rtl/sgpa_back.sv
// Back end: divider, banked grid memories, bilinear blend, Euler step, respawn.
// Depends on sgpa_pkg, sgpa_div and sgpa_out_if.
module sgpa_back #(
	parameter int INNER_COLUMNS = 62,
	parameter int INNER_ROWS    = 62,
	parameter int MAX_PARTICLES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sgpa_pkg::cfg_t  cfg,
	input  sgpa_pkg::item_t head,
	input  logic            empty,
	output logic            pop,
	sgpa_out_if.source      out_ch
);
	import sgpa_pkg::*;

	localparam int HI_X  = (INNER_COLUMNS + 1 > GRID_MAX) ? GRID_MAX : INNER_COLUMNS + 1;
	localparam int HI_Y  = (INNER_ROWS + 1 > GRID_MAX) ? GRID_MAX : INNER_ROWS + 1;
	localparam int BND_X = INNER_COLUMNS + 1;
	localparam int BND_Y = INNER_ROWS + 1;

	logic adv;
	logic out_vld_s8;

	assign adv = !out_vld_s8 || out_ch.ready;
	assign pop = adv && !empty;

	// side line alongside the divider; particle index reduced one bit a stage
	item_t       sb_q [QW+1];
	logic [QW:0] sbv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sbv_q <= '0;
		else if (adv)
			sbv_q <= {sbv_q[QW-1:0], pop};
	end

	always_ff @(posedge clk) begin
		if (adv)
			sb_q[0] <= head;
	end

	for (genvar s = 1; s <= QW; s++) begin : g_sb
		localparam int SH = (s <= IDX_BITS) ? IDX_BITS - s : 0;
		localparam logic [27:0] MSH = 28'(MAX_PARTICLES) << SH;
		item_t nxt;

		always_comb begin
			nxt = sb_q[s-1];
			if ({18'b0, sb_q[s-1].particle_index} >= MSH)
				nxt.particle_index = sb_q[s-1].particle_index - MSH[IDX_BITS-1:0];
		end

		always_ff @(posedge clk) begin
			if (adv)
				sb_q[s] <= nxt;
		end
	end

	// axis dividers: u is x-plain / y-half, v is x-half / y-plain
	logic [GRID_BITS-1:0] ki [2];
	logic [GRID_BITS-1:0] kj [2];
	logic [FW:0]          fi [2];
	logic [FW:0]          fj [2];

	sgpa_div #(.HI(HI_X), .HALF(1'b0)) u_div_ux (
		.clk(clk), .en(adv), .p(head.pos_x), .d(cfg.dx), .k(ki[0]), .f(fi[0]));
	sgpa_div #(.HI(HI_Y), .HALF(1'b1)) u_div_uy (
		.clk(clk), .en(adv), .p(head.pos_y), .d(cfg.dy), .k(kj[0]), .f(fj[0]));
	sgpa_div #(.HI(HI_X), .HALF(1'b1)) u_div_vx (
		.clk(clk), .en(adv), .p(head.pos_x), .d(cfg.dx), .k(ki[1]), .f(fi[1]));
	sgpa_div #(.HI(HI_Y), .HALF(1'b0)) u_div_vy (
		.clk(clk), .en(adv), .p(head.pos_y), .d(cfg.dy), .k(kj[1]), .f(fj[1]));

	item_t it;
	logic  itv;
	assign it  = sb_q[QW];
	assign itv = sbv_q[QW];

	// four banks per grid by (row parity, column parity): the four corners never collide
	logic [BANK_AW-1:0] raddr [2][4];
	logic [1:0]         wr_en;
	logic [1:0]         wbank;
	logic [BANK_AW-1:0] waddr;

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			for (int b = 0; b < 4; b++) begin
				logic [GRID_BITS-1:0] col, row;
				col = (ki[g][0] == b[0]) ? ki[g] : ki[g] - 1'b1;
				row = (kj[g][0] == b[1]) ? kj[g] : kj[g] - 1'b1;
				raddr[g][b] = {row[GRID_BITS-1:1], col[GRID_BITS-1:1]};
			end
		end
		wr_en[0] = itv && (it.kind == KIND_WR_U);
		wr_en[1] = itv && (it.kind == KIND_WR_V);
		wbank    = {it.grid_row[0], it.column[0]};
		waddr    = {it.grid_row[GRID_BITS-1:1], it.column[GRID_BITS-1:1]};
	end

	logic signed [31:0] rd_s1 [2][4];

	for (genvar g = 0; g < 2; g++) begin : g_grid
		for (genvar b = 0; b < 4; b++) begin : g_bank
			logic [31:0] mem_q [BANK_DEPTH];

			always_ff @(posedge clk) begin
				if (adv && wr_en[g] && (wbank == 2'(b)))
					mem_q[waddr] <= it.velocity;
				if (adv)
					rd_s1[g][b] <= mem_q[raddr[g][b]];
			end
		end
	end

	// stage 1: read data, fractions, parities
	logic                vld_s1;
	logic [1:0]          i0_s1, j0_s1;
	logic [FW:0]         fx_s1 [2];
	logic [FW:0]         fy_s1 [2];
	logic signed [31:0]  x_s1, y_s1;
	logic [IDX_BITS-1:0] idx_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < 2; g++) begin
				i0_s1[g] <= ki[g][0];
				j0_s1[g] <= kj[g][0];
				fx_s1[g] <= fi[g];
				fy_s1[g] <= fj[g];
			end
			x_s1   <= it.pos_x;
			y_s1   <= it.pos_y;
			idx_s1 <= it.particle_index;
		end
	end

	// stage 2: row blends and respawn products
	logic signed [51:0] lo_s2 [2];
	logic signed [51:0] up_s2 [2];
	logic [FW:0]        fy_s2 [2];
	logic signed [31:0] x_s2, y_s2;
	logic signed [43:0] prx_s2, pry_s2;
	logic               vld_s2;
	logic [IDX_BITS:0]  kp;

	assign kp = {1'b0, idx_s1} + 1'b1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < 2; g++) begin
				lo_s2[g] <= lerp(rd_s1[g][{~j0_s1[g], ~i0_s1[g]}],
					rd_s1[g][{~j0_s1[g], i0_s1[g]}], fx_s1[g]);
				up_s2[g] <= lerp(rd_s1[g][{j0_s1[g], ~i0_s1[g]}],
					rd_s1[g][{j0_s1[g], i0_s1[g]}], fx_s1[g]);
				fy_s2[g] <= fy_s1[g];
			end
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			prx_s2 <= 44'($signed({1'b0, kp}) * cfg.seed_step_x);
			pry_s2 <= 44'($signed({1'b0, kp}) * cfg.seed_step_y);
		end
	end

	// stage 3: round row blends, saturate seed positions
	logic signed [31:0] lo_s3 [2];
	logic signed [31:0] up_s3 [2];
	logic [FW:0]        fy_s3 [2];
	logic signed [31:0] x_s3, y_s3, rx_s3, ry_s3;
	logic               vld_s3;
	logic signed [63:0] lo_r [2];
	logic signed [63:0] up_r [2];

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			lo_r[g] = rnd16(64'(lo_s2[g]));
			up_r[g] = rnd16(64'(up_s2[g]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < 2; g++) begin
				lo_s3[g] <= lo_r[g][31:0];
				up_s3[g] <= up_r[g][31:0];
				fy_s3[g] <= fy_s2[g];
			end
			x_s3  <= x_s2;
			y_s3  <= y_s2;
			rx_s3 <= sat32(64'(cfg.seed_x) + 64'(prx_s2));
			ry_s3 <= sat32(64'(cfg.seed_y) + 64'(pry_s2));
		end
	end

	// stage 4: column blend
	logic signed [51:0] fin_s4 [2];
	logic signed [31:0] x_s4, y_s4, rx_s4, ry_s4;
	logic               vld_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < 2; g++)
				fin_s4[g] <= lerp(lo_s3[g], up_s3[g], fy_s3[g]);
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			rx_s4 <= rx_s3;
			ry_s4 <= ry_s3;
		end
	end

	// stage 5: interpolated velocities
	logic signed [31:0] vel_s5 [2];
	logic signed [31:0] x_s5, y_s5, rx_s5, ry_s5;
	logic               vld_s5;
	logic signed [63:0] fin_r [2];

	always_comb begin
		for (int g = 0; g < 2; g++)
			fin_r[g] = rnd16(64'(fin_s4[g]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < 2; g++)
				vel_s5[g] <= fin_r[g][31:0];
			x_s5  <= x_s4;
			y_s5  <= y_s4;
			rx_s5 <= rx_s4;
			ry_s5 <= ry_s4;
		end
	end

	// stage 6: time step products
	logic signed [63:0] tp_s6 [2];
	logic signed [31:0] x_s6, y_s6, rx_s6, ry_s6;
	logic               vld_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < 2; g++)
				tp_s6[g] <= 64'($signed({1'b0, cfg.time_step}) * vel_s5[g]);
			x_s6  <= x_s5;
			y_s6  <= y_s5;
			rx_s6 <= rx_s5;
			ry_s6 <= ry_s5;
		end
	end

	// stage 7: Euler sum
	logic signed [31:0] nx_s7, ny_s7, rx_s7, ry_s7;
	logic               vld_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s7 <= sat32(64'(x_s6) + rnd16(tp_s6[0]));
			ny_s7 <= sat32(64'(y_s6) + rnd16(tp_s6[1]));
			rx_s7 <= rx_s6;
			ry_s7 <= ry_s6;
		end
	end

	// stage 8: domain test and output register
	logic [41:0]        bx, by;
	logic               ood;
	logic signed [31:0] new_x_s8, new_y_s8;
	logic               resp_s8;

	always_comb begin
		bx  = 42'(cfg.dx) * 42'(BND_X);
		by  = 42'(cfg.dy) * 42'(BND_Y);
		ood = nx_s7[31] || ny_s7[31] ||
			({11'b0, nx_s7[30:0]} > bx) || ({11'b0, ny_s7[30:0]} > by);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			new_x_s8 <= ood ? rx_s7 : nx_s7;
			new_y_s8 <= ood ? ry_s7 : ny_s7;
			resp_s8  <= ood;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			vld_s7     <= 1'b0;
			out_vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1     <= itv && (it.kind == KIND_ADVECT);
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			vld_s6     <= vld_s5;
			vld_s7     <= vld_s6;
			out_vld_s8 <= vld_s7;
		end
	end

	assign out_ch.valid     = out_vld_s8;
	assign out_ch.new_x     = new_x_s8;
	assign out_ch.new_y     = new_y_s8;
	assign out_ch.respawned = resp_s8;
endmodule

>>> rtl/staggered_grid_particle_advect_top.sv
// Top level of the staggered-grid particle advection block.
// Depends on sgpa_pkg, sgpa_in_if, sgpa_out_if, sgpa_front, sgpa_fifo, sgpa_back.
//
// One input beat per clock is taken unless the queue fills: grid writes (func 0 for
// the horizontal field, 1 for the vertical field) and advect requests (func 2) all
// share one in-order path, so an advect sees every write accepted before it and
// none after. func 3 is accepted and discarded. Each advect beat yields one result
// beat, passing through the front register, a 4-entry queue, the bit-per-stage
// divider that finds the cell index and fraction from cell_width/cell_height, then
// memory read, two bilinear blends, the Euler multiply and the domain test with
// respawn. A stalled result output stalls the whole back pipeline; the front and
// queue keep accepting until the queue fills. Both velocity fields live in eight
// 1024x32 banks (four per field, split by row and column parity) and hold garbage
// until written; there is no clearing pass. Registers are on the APB port at byte
// address 4*index and must only be written while no item is in flight.
module staggered_grid_particle_advect_top #(
	parameter int INNER_COLUMNS = 62,
	parameter int INNER_ROWS    = 62,
	parameter int MAX_PARTICLES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sgpa_in_if.sink                   in_ch,
	sgpa_out_if.source                out_ch,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sgpa_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import sgpa_pkg::*;

	// configuration registers
	logic [30:0]        time_step_q, cell_width_q, cell_height_q;
	logic signed [31:0] seed_x_q, seed_y_q, seed_step_x_q, seed_step_y_q;
	logic [2:0]         reg_idx;
	cfg_t               cfg;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= 31'd6554;
			cell_width_q  <= 31'd65536;
			cell_height_q <= 31'd65536;
			seed_x_q      <= '0;
			seed_y_q      <= '0;
			seed_step_x_q <= '0;
			seed_step_y_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_TIME_STEP:   time_step_q   <= pwdata[30:0];
				REG_CELL_WIDTH:  cell_width_q  <= pwdata[30:0];
				REG_CELL_HEIGHT: cell_height_q <= pwdata[30:0];
				REG_SEED_X:      seed_x_q      <= pwdata;
				REG_SEED_Y:      seed_y_q      <= pwdata;
				REG_SEED_STEP_X: seed_step_x_q <= pwdata;
				REG_SEED_STEP_Y: seed_step_y_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TIME_STEP:   prdata = {1'b0, time_step_q};
			REG_CELL_WIDTH:  prdata = {1'b0, cell_width_q};
			REG_CELL_HEIGHT: prdata = {1'b0, cell_height_q};
			REG_SEED_X:      prdata = seed_x_q;
			REG_SEED_Y:      prdata = seed_y_q;
			REG_SEED_STEP_X: prdata = seed_step_x_q;
			REG_SEED_STEP_Y: prdata = seed_step_y_q;
			default:         prdata = '0;
		endcase
	end

	// a zero cell size acts as one LSB
	always_comb begin
		cfg.time_step   = time_step_q;
		cfg.dx          = (cell_width_q == '0) ? 31'd1 : cell_width_q;
		cfg.dy          = (cell_height_q == '0) ? 31'd1 : cell_height_q;
		cfg.seed_x      = seed_x_q;
		cfg.seed_y      = seed_y_q;
		cfg.seed_step_x = seed_step_x_q;
		cfg.seed_step_y = seed_step_y_q;
	end

	// front -> queue -> back
	logic  push, full, pop, empty;
	item_t fr_item, head;

	sgpa_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.full(full), .push(push), .item(fr_item)
	);

	sgpa_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(fr_item), .full(full),
		.pop(pop), .dout(head), .empty(empty)
	);

	sgpa_back #(
		.INNER_COLUMNS(INNER_COLUMNS),
		.INNER_ROWS(INNER_ROWS),
		.MAX_PARTICLES(MAX_PARTICLES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .head(head), .empty(empty),
		.pop(pop), .out_ch(out_ch)
	);
endmodule

>>> rtl/sgpa_chk.sv
// Port-level checker for the particle advection top level, with its bind.
// Depends on sgpa_pkg for the func codes.
module sgpa_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [31:0] out_new_x,
	input logic [31:0] out_new_y,
	input logic       out_respawned
);
	import sgpa_pkg::*;

	logic [6:0] pending_q;
	logic       adv_acc, res_acc;

	assign adv_acc = in_valid && in_ready && (in_func == FUNC_ADVECT);
	assign res_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (adv_acc && !res_acc)
			pending_q <= pending_q + 1'b1;
		else if (res_acc && !adv_acc)
			pending_q <= pending_q - 1'b1;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_new_x) &&
		$stable(out_new_y) && $stable(out_respawned))
		else $error("result beat changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 7'd0)
		else $error("result beat without an outstanding advect");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 7'd0 |=> !out_valid)
		else $error("result beat appeared with nothing in flight");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");
endmodule

bind staggered_grid_particle_advect_top sgpa_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.func),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_new_x(out_ch.new_x), .out_new_y(out_ch.new_y),
	.out_respawned(out_ch.respawned)
);

>>> bench/staggered_grid_particle_advect_top_test.sv
// Testbench for staggered_grid_particle_advect_top: grid loads, advect beats and APB setup.
// Predicts every result in-bench and checks it against the DUT output, beat by beat.
// Depends on sgpa_pkg, sgpa_in_if, sgpa_out_if and the RTL top level.
module staggered_grid_particle_advect_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sgpa_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam longint Q_ONE = 65536;
	localparam int INNER = 62;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic               respawned;
	} particle_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	sgpa_in_if  in_ch();
	sgpa_out_if out_ch();

	staggered_grid_particle_advect_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the block: registers, both velocity fields, written-entry maps
	logic [30:0]        sh_time_step, sh_cell_w, sh_cell_h;
	logic signed [31:0] sh_seed_x, sh_seed_y, sh_step_x, sh_step_y;
	logic signed [31:0] u_field [4096];
	logic signed [31:0] v_field [4096];
	bit                 u_loaded [4096];
	bit                 v_loaded [4096];

	particle_t pending_moves[$];
	int        mismatches;
	int        idle_pct;
	int        advects_sent, respawns_seen, results_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) < 0)
			q -= 1;
		return q;
	endfunction

	function automatic longint round_q(input longint v);
		return floor_div(v + 32768, Q_ONE);
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint eff_size(input logic [30:0] s);
		return (s == 0) ? 1 : longint'(s);
	endfunction

	// cell index and fraction on one axis; half shifts the samples by half a cell
	function automatic void find_cell(input longint p, input longint d, input bit half,
		output longint idx, output longint frac);
		longint n, den, k, f, hi;
		n = half ? 2 * p + d : p;
		den = half ? 2 * d : d;
		hi = (INNER + 1 > 63) ? 63 : INNER + 1;
		k = n / den + 1;
		if (k < 1) k = 1;
		if (k > hi) k = hi;
		f = floor_div((n - (k - 1) * den) * Q_ONE, den);
		if (f < 0) f = 0;
		if (f > Q_ONE) f = Q_ONE;
		idx = k;
		frac = f;
	endfunction

	function automatic int cell_addr(input longint i, input longint j);
		return int'(((j & 63) << 6) | (i & 63));
	endfunction

	function automatic longint bilerp(input bit vert, input longint x, input longint y);
		longint i, j, fx, fy, lo, up, a, b, c, d;
		find_cell(x, eff_size(sh_cell_w), vert, i, fx);
		find_cell(y, eff_size(sh_cell_h), !vert, j, fy);
		if (vert) begin
			a = longint'(v_field[cell_addr(i-1, j-1)]);
			b = longint'(v_field[cell_addr(i, j-1)]);
			c = longint'(v_field[cell_addr(i-1, j)]);
			d = longint'(v_field[cell_addr(i, j)]);
		end else begin
			a = longint'(u_field[cell_addr(i-1, j-1)]);
			b = longint'(u_field[cell_addr(i, j-1)]);
			c = longint'(u_field[cell_addr(i-1, j)]);
			d = longint'(u_field[cell_addr(i, j)]);
		end
		lo = round_q(a * (Q_ONE - fx) + b * fx);
		up = round_q(c * (Q_ONE - fx) + d * fx);
		return round_q(lo * (Q_ONE - fy) + up * fy);
	endfunction

	function automatic particle_t advance_particle(input logic signed [31:0] px,
		input logic signed [31:0] py, input logic [9:0] pidx);
		particle_t r;
		longint x, y, nx, ny, k;
		bit gone;
		x = longint'(px);
		y = longint'(py);
		nx = clip32(x + round_q(longint'(sh_time_step) * bilerp(1'b0, x, y)));
		ny = clip32(y + round_q(longint'(sh_time_step) * bilerp(1'b1, x, y)));
		gone = nx < 0 || ny < 0 || nx > (INNER + 1) * eff_size(sh_cell_w) ||
			ny > (INNER + 1) * eff_size(sh_cell_h);
		if (gone) begin
			k = longint'(pidx) + 1;
			nx = clip32(longint'(sh_seed_x) + k * longint'(sh_step_x));
			ny = clip32(longint'(sh_seed_y) + k * longint'(sh_step_y));
		end
		r.new_x = nx[31:0];
		r.new_y = ny[31:0];
		r.respawned = gone;
		return r;
	endfunction

	// result side: random back-pressure, compare against the oldest prediction
	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin
		particle_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (out_ch.respawned)
				respawns_seen++;
			if (pending_moves.size() == 0)
				report("result beat with nothing expected");
			else begin
				e = pending_moves.pop_front();
				if (out_ch.new_x !== e.new_x)
					report($sformatf("new_x %h, want %h", out_ch.new_x, e.new_x));
				if (out_ch.new_y !== e.new_y)
					report($sformatf("new_y %h, want %h", out_ch.new_y, e.new_y));
				if (out_ch.respawned !== e.respawned)
					report($sformatf("respawned %b, want %b", out_ch.respawned,
						e.respawned));
			end
		end
	end

	// one input beat; shadow state is updated at acceptance
	task automatic send_beat(input logic [1:0] fn, input logic [5:0] col,
		input logic [5:0] row, input logic signed [31:0] vel,
		input logic signed [31:0] px, input logic signed [31:0] py, input logic [9:0] pidx);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.func = fn;
		in_ch.column = col;
		in_ch.grid_row = row;
		in_ch.velocity = vel;
		in_ch.pos_x = px;
		in_ch.pos_y = py;
		in_ch.particle_index = pidx;
		do @(posedge clk); while (!in_ch.ready);
		case (fn)
			FUNC_WR_U: begin
				u_field[{row, col}] = vel;
				u_loaded[{row, col}] = 1'b1;
			end
			FUNC_WR_V: begin
				v_field[{row, col}] = vel;
				v_loaded[{row, col}] = 1'b1;
			end
			FUNC_ADVECT: begin
				pending_moves.push_back(advance_particle(px, py, pidx));
				advects_sent++;
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_velocity();
		if ($urandom_range(9) < 7)
			return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
		return $urandom;
	endfunction

	task automatic load_entry(input bit vert, input int a);
		send_beat(vert ? FUNC_WR_V : FUNC_WR_U, a[5:0], a[11:6], rand_velocity(), $urandom,
			$urandom, 10'($urandom));
	endtask

	// never let an advect touch a grid entry that was not loaded
	task automatic advect(input logic signed [31:0] px, input logic signed [31:0] py,
		input logic [9:0] pidx);
		longint i, j, f;
		int a;
		for (int vert = 0; vert < 2; vert++) begin
			find_cell(longint'(px), eff_size(sh_cell_w), bit'(vert), i, f);
			find_cell(longint'(py), eff_size(sh_cell_h), !vert, j, f);
			for (int di = -1; di <= 0; di++)
				for (int dj = -1; dj <= 0; dj++) begin
					a = cell_addr(i + di, j + dj);
					if (vert ? !v_loaded[a] : !u_loaded[a])
						load_entry(bit'(vert), a);
				end
		end
		send_beat(FUNC_ADVECT, 6'($urandom), 6'($urandom), $urandom, px, py, pidx);
	endtask

	// wait for the pipeline to empty; writes leave no result, so allow the latency too
	task automatic drain();
		in_ch.valid = 1'b0;
		wait (pending_moves.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] r, input logic [31:0] value);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = APB_AW'(r) << 2;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		case (r)
			REG_TIME_STEP:   sh_time_step = value[30:0];
			REG_CELL_WIDTH:  sh_cell_w = value[30:0];
			REG_CELL_HEIGHT: sh_cell_h = value[30:0];
			REG_SEED_X:      sh_seed_x = value;
			REG_SEED_Y:      sh_seed_y = value;
			REG_SEED_STEP_X: sh_step_x = value;
			REG_SEED_STEP_Y: sh_step_y = value;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic setup(input logic [31:0] ts, input logic [31:0] cw, input logic [31:0] ch,
		input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] stx,
		input logic [31:0] sty);
		drain();
		write_reg(REG_TIME_STEP, ts);
		write_reg(REG_CELL_WIDTH, cw);
		write_reg(REG_CELL_HEIGHT, ch);
		write_reg(REG_SEED_X, sx);
		write_reg(REG_SEED_Y, sy);
		write_reg(REG_SEED_STEP_X, stx);
		write_reg(REG_SEED_STEP_Y, sty);
	endtask

	// mostly a few cells in from the low or high edge of the domain, sometimes anywhere;
	// keeping to the edges bounds how many grid entries have to be loaded
	function automatic logic signed [31:0] rand_pos(input logic [30:0] s);
		longint p;
		int unsigned t;
		if ($urandom_range(99) < 15)
			return $urandom;
		t = $urandom_range(0, 6 * 1024);
		if ($urandom_range(0, 1) == 1)
			t += 59 * 1024;
		p = longint'(t) * eff_size(s) / 1024 - eff_size(s) / 2;
		return 32'(clip32(p));
	endfunction

	// directed: field and position extremes, unused func, index wrap, huge velocities
	task automatic test_directed();
		advect(32'sd0, 32'sd0, 10'd0);
		advect(32'sh7fffffff, 32'sh7fffffff, 10'd1023);
		advect(32'sh80000000, 32'sh80000000, 10'd512);
		advect(32'sd63 * 65536, 32'sd63 * 65536, 10'd7);
		advect(32'sd100 * 65536, -32'sd5, 10'd3);
		send_beat(FUNC_WR_U, 6'd63, 6'd63, 32'sh7fffffff, 32'sd0, 32'sd0, 10'd0);
		send_beat(FUNC_WR_V, 6'd0, 6'd0, 32'sh80000000, 32'sd0, 32'sd0, 10'd0);
		send_beat(FUNC_UNUSED, 6'd1, 6'd1, 32'sd5, 32'sd1, 32'sd1, 10'd1);
		advect(32'sd65536 / 2, 32'sd65536 / 2, 10'd100);
		advect(32'sd62 * 65536 + 32768, 32'sd62 * 65536 + 32768, 10'd1000);
		for (int n = 0; n < 6; n++)
			advect(rand_pos(sh_cell_w), rand_pos(sh_cell_h), 10'($urandom));
	endtask

	task automatic test_random(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				advect(rand_pos(sh_cell_w), rand_pos(sh_cell_h), 10'($urandom));
			else if (pick < 95)
				send_beat($urandom_range(0, 1) ? FUNC_WR_V : FUNC_WR_U, 6'($urandom),
					6'($urandom), rand_velocity(), $urandom, $urandom, 10'($urandom));
			else
				send_beat(FUNC_UNUSED, 6'($urandom), 6'($urandom), $urandom, $urandom,
					$urandom, 10'($urandom));
		end
	endtask

	task automatic test_settings();
		// moderate steps, non-square cells, respawn on a diagonal line
		setup(32'd65536, 32'd65536, 32'd32768, 32'd65536, 32'd131072, 32'd8192,
			-32'd4096);
		test_random(100);
		// extremes: largest step, zero width, largest height, seeds that saturate
		setup(32'h7fffffff, 32'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000);
		test_random(80);
		// no motion, smallest cells
		setup(32'd0, 32'd1, 32'd1, 32'hffffffff, 32'd0, 32'd1, 32'hffffffff);
		test_random(70);
		// fast flow on coarse cells, most particles leave
		setup(32'd655360, 32'd131072, 32'd131072, 32'd10 * 65536, 32'd10 * 65536,
			32'd3000, 32'd5000);
		test_random(100);
		setup(32'd6554, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.func = FUNC_WR_U; in_ch.column = '0; in_ch.grid_row = '0;
		in_ch.velocity = '0; in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.particle_index = '0;
		out_ch.ready = 1'b0;
		idle_pct = 29;
		mismatches = 0;
		sh_time_step = 31'd6554; sh_cell_w = 31'd65536; sh_cell_h = 31'd65536;
		sh_seed_x = 0; sh_seed_y = 0; sh_step_x = 0; sh_step_y = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(220);
		// back-to-back stretch, neither side idles
		idle_pct = 0;
		test_random(140);
		idle_pct = 29;
		test_settings();
		test_random(80);
		drain();

		$display("covered %0d advect beats, %0d results (%0d respawned), 5 settings",
			advects_sent, results_seen, respawns_seen);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

>>> sim.f
rtl/sgpa_pkg.sv
rtl/sgpa_in_if.sv
rtl/sgpa_out_if.sv
rtl/sgpa_front.sv
rtl/sgpa_fifo.sv
rtl/sgpa_div.sv
rtl/sgpa_back.sv
rtl/staggered_grid_particle_advect_top.sv
rtl/sgpa_chk.sv
bench/staggered_grid_particle_advect_top_test.sv
